[src/tlfu_pkg.sv]
// ----------------------------------------------------------------------------
// tlfu_pkg: shared constants and types for the TTL cache with LFU eviction
// Sizes, action and CSR codes, and the slot view and pass result of the slot scanner.
// ----------------------------------------------------------------------------
package tlfu_pkg;

   localparam int CAPACITY   = 16;
   localparam int SLOT_BITS  = $clog2(CAPACITY);
   localparam int CNT_BITS   = $clog2(CAPACITY + 1);
   localparam int KEY_BITS   = 64;
   localparam int VALUE_BITS = 64;
   localparam int TIME_BITS  = 48;
   localparam int TTL_BITS   = 32;
   localparam int USES_BITS  = 32;

   localparam logic [2:0] ACT_TICK   = 3'd0;
   localparam logic [2:0] ACT_PUT    = 3'd1;
   localparam logic [2:0] ACT_GET    = 3'd2;
   localparam logic [2:0] ACT_REMOVE = 3'd3;
   localparam logic [2:0] ACT_CLEAR  = 3'd4;

   localparam logic CSR_MAX_ENTRIES = 1'b0;
   localparam logic CSR_BASE_TTL    = 1'b1;

   // one slot as seen by the scanner
   typedef struct packed {
      logic                  valid;
      logic [KEY_BITS-1:0]   key;
      logic [TIME_BITS-1:0]  expiry;
      logic [USES_BITS-1:0]  uses;
   } slot_view_type;

   // result of a full pass over the slots
   typedef struct packed {
      logic                  found;
      logic [SLOT_BITS-1:0]  match_slot;
      logic                  any_valid;
      logic [SLOT_BITS-1:0]  min_slot;
      logic                  any_free;
      logic [SLOT_BITS-1:0]  free_slot;
      logic [CNT_BITS-1:0]   count;
   } scan_result_type;

endpackage

[src/tlfu_scan.sv]
// ----------------------------------------------------------------------------
// tlfu_scan: compare unit, one slot per cycle while step is high
// Accumulates key match, least-used slot, first free slot and valid count
// across a pass over all slots. The caller steps the slot index.
// ----------------------------------------------------------------------------
module tlfu_scan import tlfu_pkg::*; (
   input  logic                  clock,
   input  logic                  start,
   input  logic                  step,
   input  logic [SLOT_BITS-1:0]  slot,
   input  slot_view_type         view,
   input  logic [KEY_BITS-1:0]   key,
   output scan_result_type       result
);

   scan_result_type acc_ff, acc_in;
   logic [USES_BITS-1:0] min_uses_ff, min_uses_in;

   always_comb begin
      acc_in      = acc_ff;
      min_uses_in = min_uses_ff;
      if (start) begin
         acc_in      = '0;
         min_uses_in = '0;
      end else if (step) begin
         if (view.valid) begin
            acc_in.count = acc_ff.count + CNT_BITS'(1);
            if (!acc_ff.found && view.key == key) begin
               acc_in.found      = 1'b1;
               acc_in.match_slot = slot;
            end
            if (!acc_ff.any_valid || view.uses < min_uses_ff) begin
               acc_in.any_valid = 1'b1;
               acc_in.min_slot  = slot;
               min_uses_in      = view.uses;
            end
         end else if (!acc_ff.any_free) begin
            acc_in.any_free  = 1'b1;
            acc_in.free_slot = slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      min_uses_ff <= min_uses_in;
   end

   assign result = acc_ff;

endmodule

[src/ttl_cache_lfu_evict.sv]
// ----------------------------------------------------------------------------
// ttl_cache_lfu_evict: 16-entry key/value cache with expiry and LFU eviction
// Sequencer, slot storage and statistics around a shared slot scanner.
// ----------------------------------------------------------------------------
// One request at a time. Tick, clear and unknown actions go from idle through
// apply and respond; get and remove add one scan pass, one slot a cycle, through
// the shared compare unit; a put takes one count pass, and when the cache is
// at max_entries a purge pass and a second scan pass.
// The result is held in an output register; the next request is taken once
// it has been delivered. No clearing pass after reset.
module ttl_cache_lfu_evict import tlfu_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [2:0]             req_action,
   input  logic [63:0]            req_key,
   input  logic [63:0]            req_value,
   input  logic [31:0]            req_ttl,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_hit,
   output logic [63:0]            rsp_read_value,
   output logic [4:0]             rsp_occupancy,
   output logic [31:0]            rsp_hit_total,
   output logic [31:0]            rsp_miss_total,
   input  logic                   csr_write,
   input  logic                   csr_index,
   input  logic [31:0]            csr_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_PURGE = 3'd2;
   localparam logic [2:0] ST_SCAN2 = 3'd3;
   localparam logic [2:0] ST_APPLY = 3'd4;
   localparam logic [2:0] ST_RESP  = 3'd5;

   localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

   logic [2:0]            state_ff, state_in;
   logic [SLOT_BITS-1:0]  idx_ff, idx_in;
   logic                  last_slot;

   logic [2:0]            act_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic [TTL_BITS-1:0]   ttl_ff;

   logic [4:0]            max_ff;
   logic [TTL_BITS-1:0]   dttl_ff;
   logic [TIME_BITS-1:0]  now_ff;
   logic [31:0]           hits_ff, misses_ff;
   logic [CNT_BITS-1:0]   occ_ff;

   logic [CAPACITY-1:0]   valid_ff;
   logic [KEY_BITS-1:0]   key_mem   [CAPACITY];
   logic [VALUE_BITS-1:0] data_mem  [CAPACITY];
   logic [TIME_BITS-1:0]  exp_mem   [CAPACITY];
   logic [USES_BITS-1:0]  uses_mem  [CAPACITY];

   logic                  scan_start, scan_step;
   slot_view_type         view;
   scan_result_type       res;

   logic                  rsp_hit_ff;
   logic [VALUE_BITS-1:0] rsp_val_ff;
   logic                  rsp_valid_ff;

   logic [CNT_BITS-1:0]   limit;
   logic                  at_limit;
   logic                  pass_full;
   logic [CAPACITY-1:0]   put_valid;
   logic [TIME_BITS-1:0]  life, room, expiry_new;

   assign last_slot = idx_ff == SLOT_BITS'(CAPACITY - 1);

   always_comb begin
      view.valid  = valid_ff[idx_ff];
      view.key    = key_mem[idx_ff];
      view.expiry = exp_mem[idx_ff];
      view.uses   = uses_mem[idx_ff];
   end

   assign scan_start = (state_ff == ST_IDLE) || (state_ff == ST_PURGE && last_slot);
   assign scan_step  = state_ff == ST_SCAN || state_ff == ST_SCAN2;

   tlfu_scan u_scan (
      .clock  (clock),
      .start  (scan_start),
      .step   (scan_step),
      .slot   (idx_ff),
      .view   (view),
      .key    (key_ff),
      .result (res)
   );

   always_comb begin
      if (max_ff > 5'(CAPACITY))  limit = CNT_BITS'(CAPACITY);
      else if (max_ff == 5'd0)    limit = CNT_BITS'(1);
      else                        limit = CNT_BITS'(max_ff);
   end
   assign at_limit = res.count >= limit;
   // on the last slot of a pass the accumulator still lacks that slot
   assign pass_full = (res.count + CNT_BITS'(view.valid)) >= limit;

   assign life       = (ttl_ff == '0) ? TIME_BITS'(dttl_ff) : TIME_BITS'(ttl_ff);
   assign room       = TIME_MAX - now_ff;
   assign expiry_new = (life > room) ? TIME_MAX : now_ff + life;

   assign req_ready = state_ff == ST_IDLE && !rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (req_valid && req_ready) begin
               if (req_action == ACT_PUT || req_action == ACT_GET ||
                   req_action == ACT_REMOVE)
                  state_in = ST_SCAN;
               else
                  state_in = ST_APPLY;
            end
         end
         ST_SCAN, ST_PURGE, ST_SCAN2: begin
            idx_in = idx_ff + SLOT_BITS'(1);
            if (last_slot) begin
               if (state_ff == ST_SCAN && act_ff == ACT_PUT && pass_full)
                  state_in = ST_PURGE;
               else if (state_ff == ST_PURGE)
                  state_in = ST_SCAN2;
               else
                  state_in = ST_APPLY;
            end
         end
         ST_APPLY: state_in = ST_RESP;
         ST_RESP:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         max_ff       <= 5'd16;
         dttl_ff      <= 32'd600000;
         now_ff       <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         valid_ff     <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         if (csr_write) begin
            if (csr_index == CSR_MAX_ENTRIES) max_ff  <= csr_data[4:0];
            else                              dttl_ff <= csr_data;
         end
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (state_ff == ST_RESP) begin
            rsp_valid_ff <= 1'b1;
            occ_ff       <= CNT_BITS'($countones(valid_ff));
         end
         if (state_ff == ST_PURGE && valid_ff[idx_ff] && now_ff > exp_mem[idx_ff])
            valid_ff[idx_ff] <= 1'b0;
         if (state_ff == ST_APPLY) begin
            unique case (act_ff)
               ACT_TICK: if (now_ff != TIME_MAX) now_ff <= now_ff + TIME_BITS'(1);
               ACT_PUT: begin
                  valid_ff <= put_valid;
                  hits_ff  <= '0;
               end
               ACT_GET: begin
                  if (!res.found) begin
                     if (misses_ff != '1) misses_ff <= misses_ff + 32'd1;
                  end else if (now_ff > exp_mem[res.match_slot]) begin
                     valid_ff[res.match_slot] <= 1'b0;
                     if (misses_ff != '1) misses_ff <= misses_ff + 32'd1;
                  end else begin
                     if (hits_ff != '1) hits_ff <= hits_ff + 32'd1;
                  end
               end
               ACT_REMOVE: if (res.found) valid_ff[res.match_slot] <= 1'b0;
               ACT_CLEAR: begin
                  valid_ff  <= '0;
                  hits_ff   <= '0;
                  misses_ff <= '0;
               end
               default: ;
            endcase
         end
      end
   end

   // put target: matched slot if it survives, else lowest free slot; when an
   // eviction frees a slot lower than the first free one, that slot wins
   logic [SLOT_BITS-1:0] put_slot;
   always_comb begin
      if (at_limit && res.any_valid) begin
         if (res.found && res.match_slot != res.min_slot)
            put_slot = res.match_slot;
         else if (res.any_free && res.free_slot < res.min_slot)
            put_slot = res.free_slot;
         else
            put_slot = res.min_slot;
      end else if (res.found) begin
         put_slot = res.match_slot;
      end else begin
         put_slot = res.free_slot;
      end
   end

   // evict after purge only when still at the limit
   always_comb begin
      put_valid = valid_ff;
      if (at_limit && res.any_valid) put_valid[res.min_slot] = 1'b0;
      put_valid[put_slot] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid && req_ready) begin
         act_ff <= req_action;
         key_ff <= req_key;
         val_ff <= req_value;
         ttl_ff <= req_ttl;
      end
      if (state_ff == ST_APPLY) begin
         rsp_hit_ff <= 1'b0;
         rsp_val_ff <= '0;
         if (act_ff == ACT_PUT) begin
            key_mem[put_slot]  <= key_ff;
            data_mem[put_slot] <= val_ff;
            exp_mem[put_slot]  <= expiry_new;
            uses_mem[put_slot] <= '0;
         end
         if (act_ff == ACT_GET && res.found && !(now_ff > exp_mem[res.match_slot])) begin
            rsp_hit_ff <= 1'b1;
            rsp_val_ff <= data_mem[res.match_slot];
            if (uses_mem[res.match_slot] != '1)
               uses_mem[res.match_slot] <= uses_mem[res.match_slot] + USES_BITS'(1);
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = rsp_val_ff;
   assign rsp_occupancy  = occ_ff;
   assign rsp_hit_total  = hits_ff;
   assign rsp_miss_total = misses_ff;

endmodule

[src/tlfu_checker.sv]
// ----------------------------------------------------------------------------
// tlfu_checker: port-level checks for the cache
// Handshake and result sanity seen from the top-level ports.
// ----------------------------------------------------------------------------
module tlfu_checker import tlfu_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_hit,
   input logic [63:0] rsp_read_value,
   input logic [4:0]  rsp_occupancy
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while response pending");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");

   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_occupancy <= 5'(CAPACITY))
      else $error("occupancy above capacity");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_read_value == '0)
      else $error("read value on miss");

endmodule

bind ttl_cache_lfu_evict tlfu_checker u_tlfu_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_hit        (rsp_hit),
   .rsp_read_value (rsp_read_value),
   .rsp_occupancy  (rsp_occupancy)
);
